[hdl/gb3_pkg.sv]
// ----------------------------------------------------------------------------
// gb3_pkg
// shared types and constants of the 3x3 gaussian blur stream
// ----------------------------------------------------------------------------
`default_nettype none

package gb3_pkg;

  localparam int unsigned PixW     = 8;
  localparam int unsigned ResW     = 12;
  localparam int unsigned CfgDataW = 11;

  typedef logic [PixW-1:0]     pixel_t;
  typedef logic [ResW-1:0]     result_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;

  // configuration register map
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

  localparam cfg_data_t WidthReset  = 11'd640;
  localparam cfg_data_t HeightReset = 11'd480;

  // which results one pixel causes, in delivery order: inner/main result,
  // right border zero, bottom row zero, end-of-frame zero
  typedef struct packed {
    logic eof_en;
    logic bottom_en;
    logic right_en;
    logic main_en;
    logic border;
  } res_plan_t;

endpackage

`default_nettype wire

[hdl/gb3_stream_if.sv]
// ----------------------------------------------------------------------------
// gb3 stream interfaces
// valid/ready channels for pixels, results and configuration writes
// ----------------------------------------------------------------------------
`default_nettype none

interface gb3_pix_if;
  import gb3_pkg::*;
  logic   valid;
  logic   ready;
  pixel_t pixel;
  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface gb3_res_if;
  import gb3_pkg::*;
  logic    valid;
  logic    ready;
  result_t filtered_value;
  logic    last_of_run;
  logic    end_of_frame;
  modport source (output valid, output filtered_value, output last_of_run,
                  output end_of_frame, input ready);
  modport sink   (input valid, input filtered_value, input last_of_run,
                  input end_of_frame, output ready);
endinterface

interface gb3_cfg_if;
  import gb3_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_e  index;
  cfg_data_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/gb3_line_store.sv]
// ----------------------------------------------------------------------------
// gb3_line_store
// two row memories with registered read; writes rotate newer into older
// ----------------------------------------------------------------------------
`default_nettype none

module gb3_line_store #(
  parameter  int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire                 clk_i,
  input  wire                 rd_en_i,
  input  wire  [AddrW-1:0]    rd_addr_i,
  input  wire                 wr_en_i,
  input  wire  [AddrW-1:0]    wr_addr_i,
  input  wire  gb3_pkg::pixel_t wr_pixel_i,
  output gb3_pkg::pixel_t     top_o,
  output gb3_pkg::pixel_t     mid_o
);
  import gb3_pkg::*;

  pixel_t older_mem [Depth];
  pixel_t newer_mem [Depth];
  pixel_t top_q;
  pixel_t mid_q;

  // the read data still belongs to the item being written back
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      older_mem[wr_addr_i] <= mid_q;
    end
    if (rd_en_i) begin
      top_q <= older_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      newer_mem[wr_addr_i] <= wr_pixel_i;
    end
    if (rd_en_i) begin
      mid_q <= newer_mem[rd_addr_i];
    end
  end

  assign top_o = top_q;
  assign mid_o = mid_q;

endmodule

`default_nettype wire

[hdl/gb3_window.sv]
// ----------------------------------------------------------------------------
// gb3_window
// two previous columns of the active rows and the weighted kernel sum
// ----------------------------------------------------------------------------
`default_nettype none

module gb3_window (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              shift_en_i,
  input  wire  gb3_pkg::pixel_t top_i,
  input  wire  gb3_pkg::pixel_t mid_i,
  input  wire  gb3_pkg::pixel_t bot_i,
  output gb3_pkg::result_t sum_o
);
  import gb3_pkg::*;

  // [0..2] column c-2, [3..5] column c-1; top, mid, bottom
  pixel_t win_q [6];
  pixel_t win_d [6];

  always_comb begin
    win_d[0] = win_q[3];
    win_d[1] = win_q[4];
    win_d[2] = win_q[5];
    win_d[3] = top_i;
    win_d[4] = mid_i;
    win_d[5] = bot_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
    end else if (shift_en_i) begin
      for (int i = 0; i < 6; i++) win_q[i] <= win_d[i];
    end
  end

  result_t col_old;
  result_t col_prev;
  result_t col_new;

  always_comb begin
    col_old  = ResW'(win_q[0]) + (ResW'(win_q[1]) << 1) + ResW'(win_q[2]);
    col_prev = ResW'(win_q[3]) + (ResW'(win_q[4]) << 1) + ResW'(win_q[5]);
    col_new  = ResW'(top_i) + (ResW'(mid_i) << 1) + ResW'(bot_i);
    sum_o    = col_old + (col_prev << 1) + col_new;
  end

endmodule

`default_nettype wire

[hdl/gb3_emitter.sv]
// ----------------------------------------------------------------------------
// gb3_emitter
// expands one pixel's plan into up to four result words, one per cycle while res_o is ready
// ----------------------------------------------------------------------------
`default_nettype none

module gb3_emitter (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  input  wire  gb3_pkg::res_plan_t in_plan_i,
  input  wire  gb3_pkg::result_t   in_sum_i,
  output logic               in_ready_o,
  gb3_res_if.source          res_o
);
  import gb3_pkg::*;

  logic [3:0] pend_q, pend_d;
  result_t    val_q;
  logic       ovalid_q, ovalid_d;
  result_t    oval_q, oval_d;
  logic       olast_q, olast_d;
  logic       oeof_q, oeof_d;

  logic       out_free;
  logic       pop;
  logic       load;
  logic [3:0] low;
  logic [3:0] rem;
  logic [3:0] pend_after;

  always_comb begin
    out_free   = !ovalid_q || res_o.ready;
    pop        = out_free && (pend_q != 4'b0000);
    low        = pend_q & (~pend_q + 4'd1);
    rem        = pend_q & (pend_q - 4'd1);
    pend_after = pop ? rem : pend_q;
    in_ready_o = (pend_after == 4'b0000);
    load       = in_valid_i && in_ready_o;
    pend_d     = load ? {in_plan_i.eof_en, in_plan_i.bottom_en,
                         in_plan_i.right_en, in_plan_i.main_en} : pend_after;
  end

  always_comb begin
    ovalid_d = ovalid_q;
    oval_d   = oval_q;
    olast_d  = olast_q;
    oeof_d   = oeof_q;
    if (pop) begin
      ovalid_d = 1'b1;
      oval_d   = low[0] ? val_q : '0;
      olast_d  = (rem == 4'b0000);
      oeof_d   = low[3];
    end else if (res_o.ready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      val_q <= in_plan_i.border ? '0 : in_sum_i;
    end
    oval_q  <= oval_d;
    olast_q <= olast_d;
    oeof_q  <= oeof_d;
  end

  assign res_o.valid          = ovalid_q;
  assign res_o.filtered_value = oval_q;
  assign res_o.last_of_run    = olast_q;
  assign res_o.end_of_frame   = oeof_q;

endmodule

`default_nettype wire

[hdl/gaussian_blur_3x3_stream.sv]
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_stream
// 3x3 gaussian blur (1 2 1 / 2 4 2 / 1 2 1) over a raster stream of grey pixels
// ----------------------------------------------------------------------------
// Pixels enter in raster order on pix_i, one word per clock. Each pixel at row r,
// column c releases the result for row r-1, column c-1 as an exact sum in
// sixteenths (0..4080); the outer rows and columns of the frame come out as
// zero. The last pixel of a row also releases the right border zero, and the
// last row releases the bottom row zeros, so one pixel causes zero to four
// result words; last_of_run marks the final word of each pixel and
// end_of_frame marks the word for the frame's last pixel. While res_o is ready,
// the result sequencer sends one word per clock and the block takes one pixel per
// clock as long as each pixel causes at most one result; a pixel causing more
// holds the sequencer until its last word is sent. A result is registered in
// stage 1 (row memory read), in the sequencer and at its output. The user is to
// write image width and height through cfg_i (index 0 width, index 1 height,
// clamped to 3..MAX_WIDTH / 3..MAX_HEIGHT) only while the stream is idle; the
// block does not enforce it. The row memories need no clearing after reset: their
// contents only reach results that the frame border forces to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_blur_3x3_stream #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  gb3_pix_if.sink    pix_i,
  gb3_res_if.source  res_o,
  gb3_cfg_if.sink    cfg_i
);
  import gb3_pkg::*;

  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned RowW = $clog2(MAX_HEIGHT);
  localparam int unsigned WdtW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HgtW = $clog2(MAX_HEIGHT + 1);

  // configuration registers
  cfg_data_t width_cfg_q;
  cfg_data_t height_cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_cfg_q  <= WidthReset;
      height_cfg_q <= HeightReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_IMAGE_WIDTH:  width_cfg_q  <= cfg_i.data;
        REG_IMAGE_HEIGHT: height_cfg_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // effective frame size
  logic [WdtW-1:0] width_c;
  logic [HgtW-1:0] height_c;

  always_comb begin
    if (width_cfg_q < 11'd3) begin
      width_c = WdtW'(3);
    end else if (32'(width_cfg_q) > MAX_WIDTH) begin
      width_c = WdtW'(MAX_WIDTH);
    end else begin
      width_c = WdtW'(width_cfg_q);
    end
    if (height_cfg_q < 11'd3) begin
      height_c = HgtW'(3);
    end else if (32'(height_cfg_q) > MAX_HEIGHT) begin
      height_c = HgtW'(MAX_HEIGHT);
    end else begin
      height_c = HgtW'(height_cfg_q);
    end
  end

  // stage 0: position counters and result plan, row memory read issued
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            end_row;
  logic            last_row;
  logic            accept;
  res_plan_t       plan;

  // stage 1: read data back, window shift, memory write-back
  logic            s1_valid_q, s1_valid_d;
  logic [ColW-1:0] s1_addr_q;
  pixel_t          s1_pix_q;
  res_plan_t       s1_plan_q;
  logic            s1_move;
  logic            em_ready;

  pixel_t          top;
  pixel_t          mid;
  result_t         sum;

  always_comb begin
    end_row  = 32'(col_q) >= 32'(width_c) - 32'd1;
    last_row = 32'(row_q) >= 32'(height_c) - 32'd1;

    plan.main_en   = (row_q != '0) && (col_q != '0);
    plan.right_en  = (row_q != '0) && end_row;
    plan.bottom_en = last_row && (col_q != '0);
    plan.eof_en    = last_row && end_row;
    // result position is (row-1, col-1)
    plan.border    = (row_q == RowW'(1)) || (32'(row_q) >= 32'(height_c))
                  || (col_q == ColW'(1)) || (32'(col_q) >= 32'(width_c));

    if (end_row) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + RowW'(1);
    end else begin
      col_d = col_q + ColW'(1);
      row_d = row_q;
    end
  end

  // the item in stage 1 leaves once the sequencer takes its plan
  assign s1_move     = s1_valid_q && em_ready;
  assign pix_i.ready = !s1_valid_q || em_ready;
  assign accept      = pix_i.valid && pix_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_addr_q <= col_q;
      s1_pix_q  <= pix_i.pixel;
      s1_plan_q <= plan;
    end
  end

  // a column entry is rewritten at least two pixels before it is read
  // again, so the read and the write-back never meet on one address
  gb3_line_store #(
    .Depth (MAX_WIDTH)
  ) u_line_store (
    .clk_i      (clk_i),
    .rd_en_i    (accept),
    .rd_addr_i  (col_q),
    .wr_en_i    (s1_move),
    .wr_addr_i  (s1_addr_q),
    .wr_pixel_i (s1_pix_q),
    .top_o      (top),
    .mid_o      (mid)
  );

  gb3_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shift_en_i (s1_move),
    .top_i      (top),
    .mid_i      (mid),
    .bot_i      (s1_pix_q),
    .sum_o      (sum)
  );

  gb3_emitter u_emitter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s1_valid_q),
    .in_plan_i  (s1_plan_q),
    .in_sum_i   (sum),
    .in_ready_o (em_ready),
    .res_o      (res_o)
  );

endmodule

`default_nettype wire

[tb/tb_gaussian_blur_3x3_stream.sv]
// ----------------------------------------------------------------------------
// tb_gaussian_blur_3x3_stream
// self-checking bench for the 3x3 gaussian blur pixel stream
// ----------------------------------------------------------------------------
// A queue of pixels feeds a falling-edge driver. A rising-edge monitor runs a
// behavioral blur on every accepted pixel: two row stores, a 3x2 tap window,
// column and row counters and the two size registers. Each result word the
// block returns is checked against the oldest predicted word, field by field.
// The run starts with two tiny frames at the value extremes. Random phases
// follow, with register writes at frame starts and mid-frame, and
// out-of-range sizes that must clamp. One frame of forty-pixel rows has
// no idling on either side. Between phases the sender waits until every
// predicted word has come back.
// ----------------------------------------------------------------------------

module tb_gaussian_blur_3x3_stream;
  import gb3_pkg::*;

  localparam int unsigned MaxDim       = 1024;  // MAX_WIDTH and MAX_HEIGHT
  localparam int unsigned SettleCycles = 6;     // pipe drain plus margin
  localparam int unsigned StallLimit   = 2000;  // cycles with no handshake
  localparam int unsigned RandomPixels = 410;
  localparam int unsigned SteadyWidth  = 40;    // row length of the no-idle frame

  // one predicted result word
  typedef struct packed {
    result_t value;
    logic    run_end;
    logic    frame_end;
  } blur_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  gb3_pix_if pix_bus ();
  gb3_res_if res_bus ();
  gb3_cfg_if cfg_bus ();

  gaussian_blur_3x3_stream #(
    .MAX_WIDTH (MaxDim),
    .MAX_HEIGHT(MaxDim)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix_i (pix_bus),
    .res_o (res_bus),
    .cfg_i (cfg_bus)
  );

  always #4 clk_i = ~clk_i;

  // -------------------------------------------------------------------------
  // blur predictor state
  // -------------------------------------------------------------------------
  pixel_t      prev2_row [MaxDim];   // row r-2, read as the top tap
  pixel_t      prev_row  [MaxDim];   // row r-1, read as the middle tap
  pixel_t      taps      [6];        // [0..2] column c-2, [3..5] column c-1
  int unsigned col_writes[MaxDim];   // writes per column, saturating at 2
  int unsigned col_cnt;
  int unsigned row_cnt;
  cfg_data_t   width_reg;
  cfg_data_t   height_reg;

  blur_word_t  pending_blur[$];      // predicted words not yet returned
  pixel_t      pixels_to_send[$];    // stimulus not yet on the bus

  // bookkeeping shared by driver, monitor and stimulus
  bit          pix_busy;             // a pixel is on the bus, not yet taken
  bit          steady;               // no idling on either side
  int unsigned cfg_writes;
  int unsigned pixels_in;
  int unsigned words_checked;
  int unsigned frames_seen;
  int unsigned mismatches;
  int unsigned stuck_cycles;

  initial begin
    foreach (prev2_row[i]) begin
      prev2_row[i]  = '0;
      prev_row[i]   = '0;
      col_writes[i] = 0;
    end
    foreach (taps[i]) taps[i] = '0;
    col_cnt    = 0;
    row_cnt    = 0;
    width_reg  = WidthReset;
    height_reg = HeightReset;
  end

  // size actually used: registers clamp to 3..MaxDim
  function automatic int unsigned dim_used(cfg_data_t v);
    if (v < 3) return 3;
    if (v > MaxDim) return MaxDim;
    return v;
  endfunction

  function automatic void queue_word(int unsigned v, logic eof);
    blur_word_t wd;
    wd.value     = result_t'(v);
    wd.run_end   = 1'b0;
    wd.frame_end = eof;
    pending_blur.push_back(wd);
  endfunction

  // one accepted pixel: update row stores and taps, queue the words it causes
  function automatic void blur_step(pixel_t px);
    int unsigned w, h, c, r, top, mid, bot, sum, n;
    bit          end_row, last_row, border;
    w        = dim_used(width_reg);
    h        = dim_used(height_reg);
    c        = col_cnt;
    r        = row_cnt;
    top      = 0;
    mid      = 0;
    bot      = px;
    end_row  = (c >= w - 1);
    last_row = (r >= h - 1);
    n        = 0;
    if (c < MaxDim) begin
      top          = prev2_row[c];
      mid          = prev_row[c];
      prev2_row[c] = pixel_t'(mid);
      prev_row[c]  = px;
      if (col_writes[c] < 2) col_writes[c]++;
    end
    sum = taps[0] + 2 * taps[1] + taps[2]
        + 2 * (taps[3] + 2 * taps[4] + taps[5])
        + top + 2 * mid + bot;
    taps[0] = taps[3];
    taps[1] = taps[4];
    taps[2] = taps[5];
    taps[3] = pixel_t'(top);
    taps[4] = pixel_t'(mid);
    taps[5] = px;
    // centre word for (r-1, c-1), zero on the frame edge
    if (r >= 1 && c >= 1) begin
      border = (r - 1 == 0) || (r - 1 >= h - 1) || (c - 1 == 0) || (c - 1 >= w - 1);
      queue_word(border ? 0 : sum, 1'b0);
      n++;
    end
    // right edge zero when the row ends
    if (r >= 1 && end_row) begin
      queue_word(0, 1'b0);
      n++;
    end
    // bottom row zero on the last row
    if (last_row && c >= 1) begin
      queue_word(0, 1'b0);
      n++;
    end
    // bottom right corner closes the frame
    if (last_row && end_row) begin
      queue_word(0, 1'b1);
      n++;
    end
    if (n > 0) pending_blur[$].run_end = 1'b1;
    if (end_row) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  // leading columns whose row stores both hold written pixels
  function automatic int unsigned settled_columns();
    int unsigned k;
    k = 0;
    while (k < MaxDim && col_writes[k] >= 2) k++;
    return k;
  endfunction

  function automatic void note_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $time, what);
  endfunction

  // -------------------------------------------------------------------------
  // driver: pixel bus and result ready change on the falling edge
  // -------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && !pix_busy) begin
      if (pixels_to_send.size() != 0 && (steady || $urandom_range(99) >= 13)) begin
        pix_bus.pixel <= pixels_to_send.pop_front();
        pix_bus.valid <= 1'b1;
        pix_busy = 1'b1;
      end else begin
        pix_bus.valid <= 1'b0;
      end
    end
    res_bus.ready <= rst_ni && (steady || $urandom_range(99) >= 13);
  end

  // -------------------------------------------------------------------------
  // monitor: handshakes sampled on the rising edge
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    blur_word_t want;
    bit         moved;
    moved = 1'b0;
    if (rst_ni) begin
      // results first: a word never leaves in the cycle its pixel enters
      if (res_bus.valid && res_bus.ready) begin
        moved = 1'b1;
        words_checked++;
        if (res_bus.end_of_frame === 1'b1) frames_seen++;
        if (pending_blur.size() == 0) begin
          note_mismatch($sformatf("unexpected word value %0d last %0b eof %0b",
                                  res_bus.filtered_value, res_bus.last_of_run,
                                  res_bus.end_of_frame));
        end else begin
          want = pending_blur.pop_front();
          if (res_bus.filtered_value !== want.value ||
              res_bus.last_of_run !== want.run_end ||
              res_bus.end_of_frame !== want.frame_end)
            note_mismatch($sformatf(
              "expected value %0d last %0b eof %0b, got value %0d last %0b eof %0b",
              want.value, want.run_end, want.frame_end, res_bus.filtered_value,
              res_bus.last_of_run, res_bus.end_of_frame));
        end
      end
      if (pix_bus.valid && pix_bus.ready) begin
        moved = 1'b1;
        pixels_in++;
        blur_step(pix_bus.pixel);
        pix_busy = 1'b0;
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        moved = 1'b1;
        cfg_writes++;
        if (cfg_bus.index == REG_IMAGE_WIDTH) width_reg = cfg_bus.data;
        else height_reg = cfg_bus.data;
      end
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= StallLimit) begin
        $display("watchdog: no handshake for %0d cycles", StallLimit);
        $display("[gaussian_blur_3x3_stream] ERROR");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // stimulus
  // -------------------------------------------------------------------------

  // register write on its own channel, only while the stream is idle
  task automatic write_reg(cfg_idx_e idx, cfg_data_t val);
    int unsigned seen;
    seen = cfg_writes;
    @(negedge clk_i);
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    cfg_bus.valid <= 1'b1;
    do @(negedge clk_i); while (cfg_writes == seen);
    cfg_bus.valid <= 1'b0;
  endtask

  // sender holds off until every predicted word is back, then lets the
  // pipe empty out for pixels that caused no word
  task automatic wait_drained();
    while (pixels_to_send.size() != 0 || pix_busy || pending_blur.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // mostly small rows; raw 0..2 checks the lower clamp
  function automatic cfg_data_t pick_width(int unsigned limit);
    int unsigned v;
    case ($urandom_range(9))
      0:             v = $urandom_range(2);
      1, 2, 3, 4, 5: v = $urandom_range(3, 8);
      6, 7, 8:       v = $urandom_range(9, 24);
      default:       v = $urandom_range(25, 40);
    endcase
    if (v > limit) v = limit;
    return cfg_data_t'(v);
  endfunction

  // short frames, now and then a tall one that gets cut mid-frame
  function automatic cfg_data_t pick_height();
    case ($urandom_range(11))
      0:       return cfg_data_t'($urandom_range(2));
      1:       return cfg_data_t'(MaxDim);
      2:       return cfg_data_t'($urandom_range(MaxDim + 1, 2047));
      default: return cfg_data_t'($urandom_range(3, 6));
    endcase
  endfunction

  function automatic pixel_t pick_pixel();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return pixel_t'($urandom_range(255));
    endcase
  endfunction

  initial begin
    int unsigned random_fed, n, w, h, rows_after, left, safe;
    bit          big_done;

    rst_ni         = 1'b0;
    pix_bus.valid  = 1'b0;
    pix_bus.pixel  = '0;
    res_bus.ready  = 1'b0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = REG_IMAGE_WIDTH;
    cfg_bus.data   = '0;
    pix_busy       = 1'b0;
    steady         = 1'b0;
    cfg_writes     = 0;
    pixels_in      = 0;
    words_checked  = 0;
    frames_seen    = 0;
    mismatches     = 0;
    stuck_cycles   = 0;
    random_fed     = 0;
    big_done       = 1'b0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // smallest frame, all white: centre word hits the 4080 ceiling
    write_reg(REG_IMAGE_WIDTH, 11'd3);
    write_reg(REG_IMAGE_HEIGHT, 11'd3);
    repeat (9) pixels_to_send.push_back(8'hFF);
    wait_drained();

    // too-small sizes clamp to 3; black and white alternate
    write_reg(REG_IMAGE_WIDTH, 11'd0);
    write_reg(REG_IMAGE_HEIGHT, 11'd2);
    for (int i = 0; i < 9; i++) pixels_to_send.push_back(i[0] ? 8'hFF : 8'h00);
    wait_drained();

    while (random_fed < RandomPixels) begin
      if (col_cnt == 0 && row_cnt == 0) begin
        if (!big_done && random_fed >= RandomPixels / 2) begin
          // forty-pixel rows, three rows, no idling
          write_reg(REG_IMAGE_WIDTH, cfg_data_t'(SteadyWidth));
          write_reg(REG_IMAGE_HEIGHT, 11'd3);
          steady = 1'b1;
          repeat (3 * SteadyWidth) pixels_to_send.push_back(pick_pixel());
          random_fed += 3 * SteadyWidth;
          wait_drained();
          steady   = 1'b0;
          big_done = 1'b1;
          continue;
        end
        if ($urandom_range(3) != 0) write_reg(REG_IMAGE_WIDTH, pick_width(MaxDim));
        if ($urandom_range(3) != 0) write_reg(REG_IMAGE_HEIGHT, pick_height());
      end else if ($urandom_range(1) == 0) begin
        // mid-frame: counters are kept, a smaller limit ends the row or frame
        if ($urandom_range(1) == 0)
          write_reg(REG_IMAGE_HEIGHT, cfg_data_t'($urandom_range(6)));
        // a wider row may only reach columns whose stores were filled
        safe = settled_columns();
        if (safe >= 3 && $urandom_range(1) == 0)
          write_reg(REG_IMAGE_WIDTH, pick_width(safe));
      end

      w          = dim_used(width_reg);
      h          = dim_used(height_reg);
      rows_after = (row_cnt >= h - 1) ? 0 : h - 1 - row_cnt;
      left       = ((col_cnt >= w - 1) ? 1 : w - col_cnt) + rows_after * w;
      if (left <= 240 && $urandom_range(3) != 0) n = left;
      else n = $urandom_range(1, 3 * w);
      if (n > RandomPixels - random_fed) n = RandomPixels - random_fed;
      repeat (n) pixels_to_send.push_back(pick_pixel());
      random_fed += n;
      wait_drained();
    end

    wait_drained();
    if (pending_blur.size() != 0)
      $display("%0d predicted words never arrived", pending_blur.size());
    $display("fed %0d pixels, checked %0d result words over %0d frame ends, %0d reg writes",
             pixels_in, words_checked, frames_seen, cfg_writes);
    $display("rows 3 to 40 wide, clamped sizes, mid-frame resizes, %0d mismatches",
             mismatches);
    if (mismatches == 0 && pending_blur.size() == 0) begin
      $display("[gaussian_blur_3x3_stream] OK");
    end else begin
      $display("[gaussian_blur_3x3_stream] ERROR");
    end
    $finish;
  end

endmodule
